// File: design/assert_macros.svh
// Assertion macros shared by the heartbeat monitor modules.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define HM_ASSERT(lbl, clk, rst_n, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("assertion failed");
`define HM_NEVER(lbl, clk, rst_n, expr) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) \
        else $error("forbidden condition seen");
`else
`define HM_ASSERT(lbl, clk, rst_n, prop)
`define HM_NEVER(lbl, clk, rst_n, expr)
`endif
`endif

// File: design/hrpm_pkg.sv
// Types and constants of the heartbeat rate and power monitor.
package hrpm_pkg;

    localparam int IN_W    = 176;
    localparam int OUT_W   = 416;
    localparam int FIG_W   = 48;
    localparam int A_W     = 64;
    localparam int PROD_W  = 94;
    localparam int NUM_W   = 110;
    localparam int STEP_W  = 7;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 7;
    localparam int MEM_W   = 128;

    localparam logic [29:0] NS_PER_S = 30'd1000000000;
    localparam logic [47:0] SAT48    = 48'hFFFF_FFFF_FFFF;

    localparam logic [CFG_IDX_W-1:0] REG_WINDOW_LENGTH = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_ENERGY_EXP    = 2'd1;

    localparam logic [6:0] WINDOW_LENGTH_RST = 7'd64;
    localparam logic [4:0] ENERGY_EXP_RST    = 5'd14;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_READ,
        ST_UPDATE,
        ST_DIV_START,
        ST_DIV_WAIT,
        ST_OUT
    } hm_state_t;

    typedef enum logic [2:0] {
        DV_IDLE,
        DV_MUL_LO,
        DV_MUL_HI,
        DV_LOAD,
        DV_STEP,
        DV_FIN
    } dv_state_t;

    typedef enum logic [2:0] {
        FIG_WIN_RATE,
        FIG_INST_RATE,
        FIG_GLB_RATE,
        FIG_WIN_ACC,
        FIG_GLB_ACC,
        FIG_WIN_POW,
        FIG_INST_POW,
        FIG_GLB_POW
    } fig_t;

    typedef struct packed {
        logic       start;
        logic       scaled;
        logic       neg;
        logic [4:0] shift;
    } dv_req_t;

    typedef struct packed {
        logic             done;
        logic [FIG_W-1:0] q;
    } dv_rsp_t;

endpackage

// File: design/heartbeat_rate_power_monitor_unit.sv
// Heartbeat rate, accuracy and power monitor, top level.
//
// One result per heartbeat. The first beat after reset reports zero
// rates and powers. Every later beat goes through these steps:
// a read and a write of the window entry memory, then eight quotients
// (three rates, two accuracy means, three powers) on one shared divider
// that retires one quotient bit per clock over a 110-bit numerator. A new
// beat is taken while the previous result still waits on the output.
// Writing window_length empties the window. Rates and powers are unsigned
// Q32.16 and saturate to all ones on overflow or a zero time base.
`include "assert_macros.svh"

module heartbeat_rate_power_monitor_unit
    import hrpm_pkg::*;
#(
    parameter int WINDOW_MAX = 64
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  s_tvalid,
    output logic                  s_tready,
    // timestamp_ns[63:0], energy_count[111:64], accuracy[143:112], tag[175:144]
    input  logic [IN_W-1:0]       s_tdata,
    output logic                  m_tvalid,
    input  logic                  m_tready,
    // beat_number[31:0], tag_echo[63:32], win_rate[111:64],
    // inst_rate[159:112], glb_rate[207:160], win_acc[239:208],
    // glb_acc[271:240], win_pow[319:272], inst_pow[367:320],
    // glb_pow[415:368]
    output logic [OUT_W-1:0]      m_tdata,
    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data
);

    localparam int SLOT_W = (WINDOW_MAX > 1) ? $clog2(WINDOW_MAX) : 1;
    localparam int CNT_W  = SLOT_W + 1;
    localparam int ISUM_W = 48 + SLOT_W;
    localparam int ASUM_W = 32 + SLOT_W;

    hm_state_t state_reg, state_next;

    logic [6:0]               wl_reg;
    logic [4:0]               exp_reg;
    logic [SLOT_W-1:0]        slot_reg;
    logic                     full_reg;
    logic [ISUM_W-1:0]        isum_reg;
    logic signed [ASUM_W-1:0] asum_reg;
    logic [ISUM_W-1:0]        esum_reg;
    logic                     seen_reg;
    logic [63:0]              first_time_reg;
    logic [63:0]              prev_time_reg;
    logic [47:0]              prev_en_reg;
    logic [31:0]              count_reg;
    logic [63:0]              atot_reg;
    logic [47:0]              etot_reg;

    logic [63:0]              ts_reg;
    logic [47:0]              en_reg;
    logic [31:0]              acc_reg;
    logic [31:0]              tag_reg;
    logic [31:0]              bnum_reg;
    logic [32:0]              beats_reg;
    logic [63:0]              dt_reg;
    logic [47:0]              de_reg;
    logic [63:0]              span_reg;
    logic [CNT_W-1:0]         n_reg;
    fig_t                     k_reg;
    logic [FIG_W-1:0]         res_reg [8];
    logic [OUT_W-1:0]         out_reg;
    logic                     m_valid_reg;

    logic                     s_accept;
    logic                     cfg_accept;
    logic                     out_load;
    logic [CNT_W-1:0]         len;
    logic [63:0]              dt;
    logic [47:0]              de;
    logic [47:0]              dt48;
    logic [MEM_W-1:0]         rdata;
    logic [ISUM_W-1:0]        isum_new;
    logic signed [ASUM_W-1:0] asum_new;
    logic [ISUM_W-1:0]        esum_new;
    logic [CNT_W-1:0]         slot_inc;
    logic [63:0]              asum_ext;
    logic                     mem_re;
    logic                     mem_we;

    dv_req_t                  dv_req;
    dv_rsp_t                  dv_rsp;
    logic                     dv_start;
    logic [A_W-1:0]           dv_a;
    logic [63:0]              dv_den;

    assign s_accept   = s_tvalid && s_tready;
    assign cfg_ready  = (state_reg == ST_IDLE);
    assign cfg_accept = cfg_valid && cfg_ready;
    assign m_tvalid   = m_valid_reg;
    assign m_tdata    = out_reg;

    always_comb
    begin
        if (wl_reg == 7'd0)
        begin
            len = CNT_W'(1);
        end
        else if (32'(wl_reg) > WINDOW_MAX)
        begin
            len = CNT_W'(WINDOW_MAX);
        end
        else
        begin
            len = CNT_W'(wl_reg);
        end
    end

    assign dt       = ts_reg - prev_time_reg;
    assign de       = en_reg - prev_en_reg;
    assign dt48     = (|dt[63:48]) ? SAT48 : dt[47:0];
    assign asum_ext = 64'(asum_reg);
    assign slot_inc = CNT_W'(slot_reg) + CNT_W'(1);

    assign isum_new = isum_reg - (full_reg ? ISUM_W'(rdata[47:0]) : '0)
                      + ISUM_W'(dt48);
    assign asum_new = asum_reg
                      - (full_reg ? ASUM_W'(signed'(rdata[79:48])) : '0)
                      + ASUM_W'(signed'(acc_reg));
    assign esum_new = esum_reg - (full_reg ? ISUM_W'(rdata[127:80]) : '0)
                      + ISUM_W'(de);

    hrpm_win_mem #(
        .DEPTH (WINDOW_MAX),
        .AW    (SLOT_W),
        .DW    (MEM_W)
    ) u_mem (
        .clk   (clk),
        .we    (mem_we),
        .waddr (slot_reg),
        .wdata ({de, acc_reg, dt48}),
        .re    (mem_re),
        .raddr (slot_reg),
        .rdata (rdata)
    );

    // divider operand select
    always_comb
    begin
        dv_a         = '0;
        dv_den       = '0;
        dv_req.start = dv_start;
        dv_req.scaled = 1'b1;
        dv_req.neg   = 1'b0;
        dv_req.shift = 5'd0;
        case (k_reg)
            FIG_WIN_RATE:
            begin
                dv_a   = A_W'(n_reg);
                dv_den = 64'(isum_reg);
            end
            FIG_INST_RATE:
            begin
                dv_a   = A_W'(1);
                dv_den = dt_reg;
            end
            FIG_GLB_RATE:
            begin
                dv_a   = A_W'(beats_reg);
                dv_den = span_reg;
            end
            FIG_WIN_ACC:
            begin
                dv_req.scaled = 1'b0;
                dv_req.neg    = asum_ext[63];
                dv_a   = asum_ext[63] ? (~asum_ext + 64'd1) : asum_ext;
                dv_den = 64'(n_reg);
            end
            FIG_GLB_ACC:
            begin
                dv_req.scaled = 1'b0;
                dv_req.neg    = atot_reg[63];
                dv_a   = atot_reg[63] ? (~atot_reg + 64'd1) : atot_reg;
                dv_den = 64'(beats_reg);
            end
            FIG_WIN_POW:
            begin
                dv_a   = A_W'(esum_reg);
                dv_den = 64'(isum_reg);
                dv_req.shift = exp_reg;
            end
            FIG_INST_POW:
            begin
                dv_a   = A_W'(de_reg);
                dv_den = dt_reg;
                dv_req.shift = exp_reg;
            end
            FIG_GLB_POW:
            begin
                dv_a   = A_W'(etot_reg);
                dv_den = span_reg;
                dv_req.shift = exp_reg;
            end
            default:
            begin
            end
        endcase
    end

    hrpm_div u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (dv_req),
        .a     (dv_a),
        .den   (dv_den),
        .rsp   (dv_rsp)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        s_tready   = 1'b0;
        mem_re     = 1'b0;
        mem_we     = 1'b0;
        dv_start   = 1'b0;
        out_load   = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                s_tready = 1'b1;
                if (s_tvalid)
                begin
                    state_next = seen_reg ? ST_READ : ST_OUT;
                end
            end
            ST_READ:
            begin
                mem_re     = 1'b1;
                state_next = ST_UPDATE;
            end
            ST_UPDATE:
            begin
                mem_we     = 1'b1;
                state_next = ST_DIV_START;
            end
            ST_DIV_START:
            begin
                dv_start   = 1'b1;
                state_next = ST_DIV_WAIT;
            end
            ST_DIV_WAIT:
            begin
                if (dv_rsp.done)
                begin
                    state_next = (k_reg == FIG_GLB_POW) ? ST_OUT : ST_DIV_START;
                end
            end
            ST_OUT:
            begin
                if (!m_valid_reg || m_tready)
                begin
                    out_load   = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wl_reg         <= WINDOW_LENGTH_RST;
            exp_reg        <= ENERGY_EXP_RST;
            slot_reg       <= '0;
            full_reg       <= 1'b0;
            isum_reg       <= '0;
            asum_reg       <= '0;
            esum_reg       <= '0;
            seen_reg       <= 1'b0;
            first_time_reg <= '0;
            prev_time_reg  <= '0;
            prev_en_reg    <= '0;
            count_reg      <= '0;
            atot_reg       <= '0;
            etot_reg       <= '0;
            k_reg          <= FIG_WIN_RATE;
            m_valid_reg    <= 1'b0;
        end
        else
        begin
            if (m_valid_reg && m_tready && !out_load)
            begin
                m_valid_reg <= 1'b0;
            end
            case (state_reg)
                ST_IDLE:
                begin
                    if (s_accept)
                    begin
                        ts_reg    <= s_tdata[63:0];
                        en_reg    <= s_tdata[111:64];
                        acc_reg   <= s_tdata[143:112];
                        tag_reg   <= s_tdata[175:144];
                        bnum_reg  <= count_reg;
                        beats_reg <= 33'(count_reg) + 33'd1;
                        count_reg <= count_reg + 32'd1;
                        atot_reg  <= atot_reg + 64'(signed'(s_tdata[143:112]));
                        if (!seen_reg)
                        begin
                            seen_reg       <= 1'b1;
                            first_time_reg <= s_tdata[63:0];
                            prev_time_reg  <= s_tdata[63:0];
                            prev_en_reg    <= s_tdata[111:64];
                            etot_reg       <= '0;
                            res_reg[FIG_WIN_RATE]  <= '0;
                            res_reg[FIG_INST_RATE] <= '0;
                            res_reg[FIG_GLB_RATE]  <= '0;
                            res_reg[FIG_WIN_ACC]   <= {16'd0, s_tdata[143:112]};
                            res_reg[FIG_GLB_ACC]   <= {16'd0, s_tdata[143:112]};
                            res_reg[FIG_WIN_POW]   <= '0;
                            res_reg[FIG_INST_POW]  <= '0;
                            res_reg[FIG_GLB_POW]   <= '0;
                        end
                    end
                end
                ST_UPDATE:
                begin
                    isum_reg      <= isum_new;
                    asum_reg      <= asum_new;
                    esum_reg      <= esum_new;
                    n_reg         <= full_reg ? len : slot_inc;
                    dt_reg        <= dt;
                    de_reg        <= de;
                    span_reg      <= ts_reg - first_time_reg;
                    etot_reg      <= etot_reg + de;
                    prev_time_reg <= ts_reg;
                    prev_en_reg   <= en_reg;
                    k_reg         <= FIG_WIN_RATE;
                    if (slot_inc >= len)
                    begin
                        slot_reg <= '0;
                        full_reg <= 1'b1;
                    end
                    else
                    begin
                        slot_reg <= slot_inc[SLOT_W-1:0];
                    end
                end
                ST_DIV_WAIT:
                begin
                    if (dv_rsp.done)
                    begin
                        res_reg[k_reg] <= dv_rsp.q;
                        k_reg          <= fig_t'(k_reg + 3'd1);
                    end
                end
                ST_OUT:
                begin
                    if (out_load)
                    begin
                        out_reg <= {res_reg[FIG_GLB_POW], res_reg[FIG_INST_POW],
                                    res_reg[FIG_WIN_POW], res_reg[FIG_GLB_ACC][31:0],
                                    res_reg[FIG_WIN_ACC][31:0], res_reg[FIG_GLB_RATE],
                                    res_reg[FIG_INST_RATE], res_reg[FIG_WIN_RATE],
                                    tag_reg, bnum_reg};
                        m_valid_reg <= 1'b1;
                    end
                end
                default:
                begin
                end
            endcase
            if (cfg_accept)
            begin
                case (cfg_index)
                    REG_WINDOW_LENGTH:
                    begin
                        wl_reg   <= cfg_data[6:0];
                        slot_reg <= '0;
                        full_reg <= 1'b0;
                        isum_reg <= '0;
                        asum_reg <= '0;
                        esum_reg <= '0;
                    end
                    REG_ENERGY_EXP:
                    begin
                        exp_reg <= cfg_data[4:0];
                    end
                    default:
                    begin
                    end
                endcase
            end
        end
    end

    `HM_ASSERT(a_accept_goes_busy, clk, rst_n, s_tvalid && s_tready |=> !s_tready)
    `HM_ASSERT(a_slot_in_window, clk, rst_n, CNT_W'(slot_reg) < len)
    `HM_ASSERT(a_div_only_after_first, clk, rst_n,
        dv_req.start |-> seen_reg && state_reg == ST_DIV_START)

endmodule

// File: design/hrpm_win_mem.sv
// Window entry memory: one write port, one registered read port.
module hrpm_win_mem #(
    parameter int DEPTH = 64,
    parameter int AW    = 6,
    parameter int DW    = 128
) (
    input  logic          clk,
    input  logic          we,
    input  logic [AW-1:0] waddr,
    input  logic [DW-1:0] wdata,
    input  logic          re,
    input  logic [AW-1:0] raddr,
    output logic [DW-1:0] rdata
);

    logic [DW-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

// File: design/hrpm_div.sv
// Shared bit-serial divider for scaled rates, powers and signed means.
`include "assert_macros.svh"

module hrpm_div
    import hrpm_pkg::*;
(
    input  logic           clk,
    input  logic           rst_n,
    input  dv_req_t        req,
    input  logic [A_W-1:0] a,
    input  logic [63:0]    den,
    output dv_rsp_t        rsp
);

    dv_state_t state_reg, state_next;

    logic [A_W-1:0]    a_reg;
    logic [63:0]       den_reg;
    logic [4:0]        shift_reg;
    logic              scaled_reg;
    logic              neg_reg;
    logic [PROD_W-1:0] prod_reg;
    logic [NUM_W-1:0]  num_reg;
    logic [63:0]       rem_reg;
    logic [STEP_W-1:0] cnt_reg;
    logic              done_reg;
    logic [FIG_W-1:0]  q_reg;

    logic [61:0]       p_lo;
    logic [61:0]       p_hi;
    logic [64:0]       rsh;
    logic              ge;
    logic [NUM_W-1:0]  qs;
    logic [31:0]       qa;
    logic [FIG_W-1:0]  q_fin;

    assign p_lo = a_reg[31:0] * NS_PER_S;
    assign p_hi = a_reg[63:32] * NS_PER_S;
    assign rsh  = {rem_reg, num_reg[NUM_W-1]};
    assign ge   = rsh >= {1'b0, den_reg};
    assign qs   = num_reg >> shift_reg;
    assign qa   = neg_reg ? (~num_reg[31:0] + 32'd1) : num_reg[31:0];

    always_comb
    begin
        if (scaled_reg)
        begin
            if (den_reg == '0 || (|qs[NUM_W-1:FIG_W]))
            begin
                q_fin = SAT48;
            end
            else
            begin
                q_fin = qs[FIG_W-1:0];
            end
        end
        else
        begin
            q_fin = {16'd0, qa};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= DV_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            DV_IDLE:
            begin
                if (req.start)
                begin
                    if (!req.scaled)
                    begin
                        state_next = DV_LOAD;
                    end
                    else if (den == '0)
                    begin
                        state_next = DV_FIN;
                    end
                    else
                    begin
                        state_next = DV_MUL_LO;
                    end
                end
            end
            DV_MUL_LO: state_next = DV_MUL_HI;
            DV_MUL_HI: state_next = DV_LOAD;
            DV_LOAD:   state_next = DV_STEP;
            DV_STEP:
            begin
                if (cnt_reg == STEP_W'(NUM_W - 1))
                begin
                    state_next = DV_FIN;
                end
            end
            DV_FIN:    state_next = DV_IDLE;
            default:   state_next = DV_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            done_reg   <= 1'b0;
            cnt_reg    <= '0;
            scaled_reg <= 1'b0;
            den_reg    <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            case (state_reg)
                DV_IDLE:
                begin
                    if (req.start)
                    begin
                        a_reg      <= a;
                        den_reg    <= den;
                        shift_reg  <= req.shift;
                        scaled_reg <= req.scaled;
                        neg_reg    <= req.neg;
                    end
                end
                DV_MUL_LO:
                begin
                    prod_reg <= PROD_W'(p_lo);
                end
                DV_MUL_HI:
                begin
                    prod_reg <= prod_reg + {p_hi[PROD_W-33:0], 32'd0};
                end
                DV_LOAD:
                begin
                    num_reg <= scaled_reg ? {prod_reg, 16'd0} : NUM_W'(a_reg);
                    rem_reg <= '0;
                    cnt_reg <= '0;
                end
                DV_STEP:
                begin
                    rem_reg <= ge ? 64'(rsh - {1'b0, den_reg}) : rsh[63:0];
                    num_reg <= {num_reg[NUM_W-2:0], ge};
                    cnt_reg <= cnt_reg + STEP_W'(1);
                end
                DV_FIN:
                begin
                    q_reg    <= q_fin;
                    done_reg <= 1'b1;
                end
                default:
                begin
                end
            endcase
        end
    end

    assign rsp.done = done_reg;
    assign rsp.q    = q_reg;

    `HM_ASSERT(a_start_leaves_idle, clk, rst_n,
        req.start && state_reg == DV_IDLE |=> state_reg != DV_IDLE)
    `HM_ASSERT(a_step_bound, clk, rst_n, cnt_reg <= STEP_W'(NUM_W))
    `HM_ASSERT(a_zero_den_sat, clk, rst_n,
        done_reg && scaled_reg && den_reg == 64'd0 |-> q_reg == SAT48)

endmodule

// File: dv/tb_heartbeat_rate_power_monitor_unit.sv
// Testbench of the heartbeat rate and power monitor: directed and random beats against a scoreboard model.
`timescale 1ns / 100ps

module tb_heartbeat_rate_power_monitor_unit
    import hrpm_pkg::*;
();

    localparam int LIMIT_CYCLES = 5000000;

    typedef struct packed {
        logic [31:0] tag;
        logic [31:0] accuracy;
        logic [47:0] energy;
        logic [63:0] stamp;
    } beat_t;

    typedef struct packed {
        logic [47:0] glb_pow;
        logic [47:0] inst_pow;
        logic [47:0] win_pow;
        logic [31:0] glb_acc;
        logic [31:0] win_acc;
        logic [47:0] glb_rate;
        logic [47:0] inst_rate;
        logic [47:0] win_rate;
        logic [31:0] tag_echo;
        logic [31:0] beat_num;
    } figs_t;

    class monitor_scoreboard;
        figs_t       pending[$];
        int          errors;
        logic [6:0]  win_len_cfg;
        logic [4:0]  exp_cfg;
        logic [47:0] ivl_mem[64];
        logic [47:0] step_mem[64];
        logic [31:0] acc_mem[64];
        int unsigned slot;
        bit          full;
        logic [63:0] ivl_sum, acc_sum, step_sum;
        bit          seen;
        logic [63:0] first_t, prev_t, acc_tot;
        logic [47:0] prev_e, e_tot;
        logic [31:0] count;

        function new();
            errors = 0;
            win_len_cfg = WINDOW_LENGTH_RST;
            exp_cfg = ENERGY_EXP_RST;
            seen = 0;
            first_t = 0;
            prev_t = 0;
            prev_e = 0;
            count = 0;
            acc_tot = 0;
            e_tot = 0;
            empty_window();
        endfunction

        function void empty_window();
            slot = 0;
            full = 0;
            ivl_sum = 0;
            acc_sum = 0;
            step_sum = 0;
        endfunction

        function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
            if (idx == REG_WINDOW_LENGTH)
            begin
                win_len_cfg = val;
                empty_window();
            end
            else if (idx == REG_ENERGY_EXP)
                exp_cfg = val[4:0];
        endfunction

        // floor(a * 1e9 * 2^16 / den) >> e, saturated to 48 bits; all ones when den is zero
        function logic [47:0] ratio(logic [63:0] a, logic [63:0] den, logic [4:0] e);
            logic [127:0] num;
            if (den == 0)
                return SAT48;
            num = {64'd0, a};
            num = num * 128'd1000000000;
            num = num << 16;
            num = num / {64'd0, den};
            num = num >> e;
            return (num > {80'd0, SAT48}) ? SAT48 : num[47:0];
        endfunction

        function logic [31:0] mean(logic [63:0] s, logic [63:0] n);
            logic signed [63:0] q;
            q = $signed(s) / $signed(n);
            return q[31:0];
        endfunction

        function void note_beat(beat_t b);
            figs_t       f;
            logic [63:0] acc64, dt, span, n, beats;
            logic [47:0] de, dt48;
            int unsigned len;
            acc64 = {{32{b.accuracy[31]}}, b.accuracy};
            beats = {32'd0, count} + 64'd1;
            f = '0;
            f.beat_num = count;
            f.tag_echo = b.tag;
            acc_tot = acc_tot + acc64;
            if (!seen)
            begin
                seen = 1;
                first_t = b.stamp;
                prev_t = b.stamp;
                prev_e = b.energy;
                e_tot = 0;
                f.win_acc = b.accuracy;
                f.glb_acc = b.accuracy;
            end
            else
            begin
                dt = b.stamp - prev_t;
                de = b.energy - prev_e;
                dt48 = (dt > {16'd0, SAT48}) ? SAT48 : dt[47:0];
                len = (win_len_cfg == 0) ? 1 : (win_len_cfg > 64 ? 64 : win_len_cfg);
                if (slot >= 64)
                    slot = 0;
                if (full)
                begin
                    ivl_sum = ivl_sum - ivl_mem[slot];
                    acc_sum = acc_sum - {{32{acc_mem[slot][31]}}, acc_mem[slot]};
                    step_sum = step_sum - step_mem[slot];
                    n = len;
                end
                else
                    n = slot + 1;
                ivl_mem[slot] = dt48;
                acc_mem[slot] = b.accuracy;
                step_mem[slot] = de;
                ivl_sum = ivl_sum + dt48;
                acc_sum = acc_sum + acc64;
                step_sum = step_sum + de;
                slot++;
                if (slot >= len)
                begin
                    slot = 0;
                    full = 1;
                end
                e_tot = e_tot + de;
                span = b.stamp - first_t;
                f.win_rate = ratio(n, ivl_sum, 5'd0);
                f.inst_rate = ratio(64'd1, dt, 5'd0);
                f.glb_rate = ratio(beats, span, 5'd0);
                f.win_acc = mean(acc_sum, n);
                f.glb_acc = mean(acc_tot, beats);
                f.win_pow = ratio(step_sum, ivl_sum, exp_cfg);
                f.inst_pow = ratio({16'd0, de}, dt, exp_cfg);
                f.glb_pow = ratio({16'd0, e_tot}, span, exp_cfg);
                prev_t = b.stamp;
                prev_e = b.energy;
            end
            count = count + 1;
            pending.push_back(f);
        endfunction

        function void field(string name, logic [47:0] want, logic [47:0] got);
            if (want !== got)
            begin
                errors++;
                if (errors <= 10)
                    $display("mismatch %s: expected %h got %h", name, want, got);
            end
        endfunction

        function void check_result(figs_t got);
            figs_t w;
            if (pending.size() == 0)
            begin
                errors++;
                if (errors <= 10)
                    $display("unexpected result transaction, beat %0d", got.beat_num);
                return;
            end
            w = pending.pop_front();
            field("beat_number", w.beat_num, got.beat_num);
            field("tag_echo", w.tag_echo, got.tag_echo);
            field("win_rate", w.win_rate, got.win_rate);
            field("inst_rate", w.inst_rate, got.inst_rate);
            field("glb_rate", w.glb_rate, got.glb_rate);
            field("win_acc", w.win_acc, got.win_acc);
            field("glb_acc", w.glb_acc, got.glb_acc);
            field("win_pow", w.win_pow, got.win_pow);
            field("inst_pow", w.inst_pow, got.inst_pow);
            field("glb_pow", w.glb_pow, got.glb_pow);
        endfunction
    endclass

    logic                  clk = 0;
    logic                  rst_n = 0;
    logic                  s_tvalid = 0;
    logic                  s_tready;
    logic [IN_W-1:0]       s_tdata = '0;
    logic                  m_tvalid;
    logic                  m_tready = 1;
    logic [OUT_W-1:0]      m_tdata;
    logic                  cfg_valid = 0;
    logic                  cfg_ready;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_data = '0;

    monitor_scoreboard sb = new();
    bit                idle_on = 1;
    int                cycles = 0;
    logic [63:0]       cur_ts = 64'd1000;
    logic [47:0]       cur_en = 48'd5;

    heartbeat_rate_power_monitor_unit DUT (
        .clk(clk),
        .rst_n(rst_n),
        .s_tvalid(s_tvalid),
        .s_tready(s_tready),
        .s_tdata(s_tdata),
        .m_tvalid(m_tvalid),
        .m_tready(m_tready),
        .m_tdata(m_tdata),
        .cfg_valid(cfg_valid),
        .cfg_ready(cfg_ready),
        .cfg_index(cfg_index),
        .cfg_data(cfg_data)
    );

    always
    begin
        #5 clk = 1;
        #5 clk = 0;
    end

    always @(posedge clk)
    begin
        cycles++;
        if (cycles > LIMIT_CYCLES)
        begin
            $display("FAILURE");
            $finish;
        end
        if (rst_n && m_tvalid && m_tready)
            sb.check_result(m_tdata);
    end

    initial
    begin
        int k;
        @(posedge rst_n);
        forever
        begin
            k = idle_on ? $urandom_range(0, 6) : 0;
            if (k > 0)
            begin
                @(negedge clk);
                m_tready <= 0;
                repeat (k) @(negedge clk);
                m_tready <= 1;
            end
            do @(posedge clk); while (!(m_tvalid && m_tready));
        end
    end

    task automatic send_beat(logic [63:0] ts, logic [47:0] en, logic [31:0] acc,
                             logic [31:0] tag);
        beat_t b;
        int    k;
        b = '{tag: tag, accuracy: acc, energy: en, stamp: ts};
        k = idle_on ? $urandom_range(0, 6) : 0;
        @(negedge clk);
        if (k > 0)
        begin
            s_tvalid <= 0;
            repeat (k) @(negedge clk);
        end
        s_tvalid <= 1;
        s_tdata <= b;
        do @(posedge clk); while (!s_tready);
        sb.note_beat(b);
        cur_ts = ts;
        cur_en = en;
    endtask

    task automatic write_cfg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
        @(negedge clk);
        s_tvalid <= 0;
        while (sb.pending.size() != 0) @(posedge clk);
        repeat (20) @(negedge clk);
        cfg_valid <= 1;
        cfg_index <= idx;
        cfg_data <= val;
        do @(posedge clk); while (!cfg_ready);
        sb.write_reg(idx, val);
        @(negedge clk);
        cfg_valid <= 0;
    endtask

    // mostly steady beats, some wild timestamps and energies
    task automatic random_beat();
        logic [63:0] ts;
        logic [47:0] en;
        int          pick;
        pick = $urandom_range(0, 99);
        if (pick < 80)
        begin
            ts = cur_ts + 64'($urandom_range(1, 2000000000));
            en = cur_en + 48'($urandom_range(0, 1 << 20));
        end
        else if (pick < 90)
        begin
            ts = cur_ts + 64'($urandom_range(0, 3));
            en = cur_en + 48'({$urandom, $urandom});
        end
        else
        begin
            ts = {$urandom, $urandom};
            en = 48'({$urandom, $urandom});
        end
        send_beat(ts, en, $urandom, $urandom);
    endtask

    initial
    begin
        logic [6:0] lens[8];
        logic [4:0] exps[8];
        lens = '{7'd1, 7'd64, 7'd127, 7'd0, 7'd3, 7'd17, 7'd65, 7'd63};
        exps = '{5'd0, 5'd31, 5'd14, 5'd1, 5'd30, 5'd7, 5'd20, 5'd2};
        repeat (12) @(posedge clk);
        @(negedge clk);
        rst_n = 1;

        // first beat, then zero interval, big energy step, backward and huge jumps
        send_beat(64'd1000, 48'd5, 32'h7FFF_FFFF, 32'h8000_0000);
        send_beat(64'd1000, 48'd5, 32'h8000_0000, 32'h7FFF_FFFF);
        send_beat(64'd1001, SAT48, 32'h0001_0000, 32'd0);
        send_beat(64'd500, 48'd0, 32'hFFFF_0000, 32'hFFFF_FFFF);
        send_beat(64'hFFFF_FFFF_FFFF_FFFF, 48'd10, 32'h0, 32'd1);
        send_beat(64'hFFFF_FFFF_FFFF_FFFF, 48'd10, 32'h7FFF_FFFF, 32'd2);
        send_beat(64'd0, SAT48, 32'h8000_0000, 32'd3);
        for (int i = 0; i < 8; i++)
            send_beat(cur_ts + 64'd1000000000, cur_en + 48'd16384, 32'h0000_8000, i);
        write_cfg(REG_WINDOW_LENGTH, 7'd1);
        write_cfg(REG_ENERGY_EXP, 7'd0);
        for (int i = 0; i < 4; i++)
            send_beat(cur_ts + 64'd1, cur_en + 48'd1, 32'hFFFF_FFFF, i);
        write_cfg(REG_ENERGY_EXP, 7'd31);
        for (int i = 0; i < 4; i++)
            send_beat(cur_ts + 64'd999, cur_en + SAT48 - 48'd1, 32'h1, i);

        for (int p = 0; p < 8; p++)
        begin
            write_cfg(REG_WINDOW_LENGTH, lens[p]);
            write_cfg(REG_ENERGY_EXP, CFG_DATA_W'(exps[p]));
            idle_on = (p % 3 != 2);
            for (int i = 0; i < 72; i++)
                random_beat();
        end

        @(negedge clk);
        s_tvalid <= 0;
        while (sb.pending.size() != 0) @(posedge clk);
        repeat (1000) @(posedge clk);
        if (sb.errors == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule
